[rtl/lru_key_value_cache_core_assert.svh]
// Assertion macros shared by the cache modules.
// Each macro expects the clock aclk and the active-low reset aresetn in scope.
// LKV_ASSERT is disabled while reset is asserted; LKV_ASSERT_NORST is always checked.
`ifndef LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`define LRU_KEY_VALUE_CACHE_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define LKV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define LKV_ASSERT_NORST(label, prop, msg) \
    label: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define LKV_ASSERT(label, prop, msg)
`define LKV_ASSERT_NORST(label, prop, msg)
`endif
`endif

[rtl/lkv_pkg.sv]
`timescale 1ns / 1ps

package lkv_pkg;

    // Field widths fixed by the interface.
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // Capacity register value after reset.
    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Operation codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Read value returned by a get that misses.
    localparam logic signed [DATA_W-1:0] MISS_VALUE = 32'hFFFF_FFFF;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SCAN_DRAIN,
        ST_DECIDE,
        ST_UPDATE,
        ST_UPD_DRAIN,
        ST_FINISH
    } lkv_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic scan_issue;
        logic decide;
        logic upd_issue;
        logic finish;
    } lkv_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic idx_last;
        logic need_upd;
    } lkv_sts_t;

endpackage

[rtl/lkv_ctrl.sv]
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_assert.svh"

module lkv_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    output logic              m_valid,
    input  logic              m_ready,
    output lkv_pkg::lkv_cmd_t cmd,
    input  lkv_pkg::lkv_sts_t sts
);

    lkv_pkg::lkv_state_t state_reg;
    lkv_pkg::lkv_state_t state_next;
    logic                m_valid_reg;
    logic                m_valid_next;
    logic                out_free;

    // The output register can take a new word when empty or being drained.
    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == lkv_pkg::ST_IDLE);
    assign m_valid  = m_valid_reg;

    // State and output valid registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= lkv_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Next state and datapath commands.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            lkv_pkg::ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = lkv_pkg::ST_SCAN;
                end
            end
            lkv_pkg::ST_SCAN: begin
                cmd.scan_issue = 1'b1;
                if (sts.idx_last) begin
                    state_next = lkv_pkg::ST_SCAN_DRAIN;
                end
            end
            lkv_pkg::ST_SCAN_DRAIN: begin
                state_next = lkv_pkg::ST_DECIDE;
            end
            lkv_pkg::ST_DECIDE: begin
                cmd.decide = 1'b1;
                state_next = sts.need_upd ? lkv_pkg::ST_UPDATE : lkv_pkg::ST_FINISH;
            end
            lkv_pkg::ST_UPDATE: begin
                cmd.upd_issue = 1'b1;
                if (sts.idx_last) begin
                    state_next = lkv_pkg::ST_UPD_DRAIN;
                end
            end
            lkv_pkg::ST_UPD_DRAIN: begin
                state_next = lkv_pkg::ST_FINISH;
            end
            lkv_pkg::ST_FINISH: begin
                if (out_free) begin
                    cmd.finish = 1'b1;
                    state_next = lkv_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lkv_pkg::ST_IDLE;
            end
        endcase
    end

    // The output word is valid from finish until it is taken.
    always_comb begin
        if (cmd.finish) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    `LKV_ASSERT(a_accept_starts_scan, (s_valid && s_ready) |=> (state_reg == lkv_pkg::ST_SCAN), "accepted word did not start a scan")
    `LKV_ASSERT(a_result_from_finish, $rose(m_valid_reg) |-> $past(state_reg == lkv_pkg::ST_FINISH), "result appeared outside finish")
    `LKV_ASSERT_NORST(a_reset_clears_out, !aresetn |=> !m_valid_reg, "reset left a result pending")

endmodule

[rtl/lkv_datapath.sv]
`timescale 1ns / 1ps
`include "lru_key_value_cache_core_assert.svh"

module lkv_datapath #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  lkv_pkg::lkv_cmd_t                  cmd,
    output lkv_pkg::lkv_sts_t                  sts,
    input  logic                               cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic                               s_operation,
    input  logic signed [lkv_pkg::DATA_W-1:0]  s_lookup_key,
    input  logic signed [lkv_pkg::DATA_W-1:0]  s_write_value,
    output logic                               m_hit,
    output logic signed [lkv_pkg::DATA_W-1:0]  m_read_value,
    output logic                               m_evicted,
    output logic signed [lkv_pkg::DATA_W-1:0]  m_evicted_key
);

    localparam int IDX_W  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int CNT_W  = $clog2(MAX_ENTRIES + 1);
    localparam int CMP_W  = (CNT_W > lkv_pkg::CAP_W) ? CNT_W : lkv_pkg::CAP_W;
    localparam int DW     = lkv_pkg::DATA_W;

    // Entry storage; the valid bits live in flip-flops so reset clears them.
    logic [DW-1:0]     key_mem  [MAX_ENTRIES];
    logic [DW-1:0]     val_mem  [MAX_ENTRIES];
    logic [RANK_W-1:0] rank_mem [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] valid_reg;

    logic [lkv_pkg::CAP_W-1:0] cap_reg;
    logic [CNT_W-1:0]          occ_reg;
    logic [CNT_W-1:0]          occ_next;

    // Sweep counter and the read pipeline stage behind it.
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    logic [IDX_W-1:0]  pidx_reg;
    logic              pscan_reg;
    logic              pupd_reg;
    logic [DW-1:0]     key_rd_reg;
    logic [DW-1:0]     val_rd_reg;
    logic [RANK_W-1:0] rank_rd_reg;
    logic [RANK_W-1:0] rank_next;

    // Request held for the duration of the operation.
    logic          op_reg;
    logic [DW-1:0] key_in_reg;
    logic [DW-1:0] val_in_reg;

    // Scan results.
    logic              found_reg;
    logic [IDX_W-1:0]  slot_reg;
    logic [DW-1:0]     hitval_reg;
    logic [RANK_W-1:0] hitrank_reg;
    logic              any_reg;
    logic [IDX_W-1:0]  lru_reg;
    logic [RANK_W-1:0] lrurank_reg;
    logic [DW-1:0]     lrukey_reg;
    logic              free_any_reg;
    logic [IDX_W-1:0]  free_reg;

    // Decision and result.
    logic             ins_mode_reg;
    logic [IDX_W-1:0] target_reg;
    logic             res_hit_reg;
    logic [DW-1:0]    res_rd_reg;
    logic             res_ev_reg;
    logic [DW-1:0]    res_evk_reg;
    logic             m_hit_reg;
    logic [DW-1:0]    m_read_value_reg;
    logic             m_evicted_reg;
    logic [DW-1:0]    m_evicted_key_reg;

    logic [CMP_W-1:0] effcap_c;
    logic             insert_c;
    logic             evict_c;
    logic [IDX_W-1:0] target_c;
    logic             pvalid_c;

    // Capacity clamped to the range 1 to MAX_ENTRIES.
    always_comb begin
        if (cap_reg == '0) begin
            effcap_c = CMP_W'(1);
        end else if (CMP_W'(cap_reg) > CMP_W'(MAX_ENTRIES)) begin
            effcap_c = CMP_W'(MAX_ENTRIES);
        end else begin
            effcap_c = CMP_W'(cap_reg);
        end
    end

    // A put miss inserts; it evicts first when occupancy has reached capacity.
    // The new entry goes to the lowest free slot, which may be the victim's.
    assign insert_c = (op_reg == lkv_pkg::OP_PUT) && !found_reg;
    assign evict_c  = insert_c && any_reg && (CMP_W'(occ_reg) >= effcap_c);
    always_comb begin
        if (found_reg) begin
            target_c = slot_reg;
        end else if (evict_c && !(free_any_reg && (free_reg < lru_reg))) begin
            target_c = lru_reg;
        end else begin
            target_c = free_reg;
        end
    end

    assign occ_next     = (insert_c && !evict_c) ? occ_reg + CNT_W'(1) : occ_reg;
    assign sts.idx_last = (idx_reg == IDX_W'(MAX_ENTRIES - 1));
    assign sts.need_upd = (op_reg == lkv_pkg::OP_PUT) || found_reg;
    assign idx_next     = sts.idx_last ? '0 : idx_reg + IDX_W'(1);
    assign pvalid_c     = valid_reg[pidx_reg];

    // Rank rewrite: the target becomes most recent, and the entries ahead of it age by one.
    always_comb begin
        if (pidx_reg == target_reg) begin
            rank_next = '0;
        end else if (pvalid_c && (ins_mode_reg || (rank_rd_reg < hitrank_reg))) begin
            rank_next = rank_rd_reg + RANK_W'(1);
        end else begin
            rank_next = rank_rd_reg;
        end
    end

    // Control registers: configuration, occupancy, valid bits and sweep pipeline.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= lkv_pkg::CAP_RESET;
            occ_reg   <= '0;
            valid_reg <= '0;
            idx_reg   <= '0;
            pidx_reg  <= '0;
            pscan_reg <= 1'b0;
            pupd_reg  <= 1'b0;
        end else begin
            if (cfg_we) begin
                cap_reg <= cfg_wdata;
            end
            if (cmd.scan_issue || cmd.upd_issue) begin
                idx_reg <= idx_next;
            end
            pidx_reg  <= idx_reg;
            pscan_reg <= cmd.scan_issue;
            pupd_reg  <= cmd.upd_issue;
            if (cmd.decide) begin
                occ_reg <= occ_next;
                if (evict_c) begin
                    valid_reg[lru_reg] <= 1'b0;
                end
                if (insert_c) begin
                    valid_reg[target_c] <= 1'b1;
                end
            end
        end
    end

    // Key and value memories: read at the sweep index, written at decide.
    always_ff @(posedge aclk) begin
        key_rd_reg <= key_mem[idx_reg];
        if (cmd.decide && (op_reg == lkv_pkg::OP_PUT)) begin
            key_mem[target_c] <= key_in_reg;
        end
    end

    always_ff @(posedge aclk) begin
        val_rd_reg <= val_mem[idx_reg];
        if (cmd.decide && (op_reg == lkv_pkg::OP_PUT)) begin
            val_mem[target_c] <= val_in_reg;
        end
    end

    // Rank memory: read at the sweep index, rewritten one entry behind it.
    always_ff @(posedge aclk) begin
        rank_rd_reg <= rank_mem[idx_reg];
        if (pupd_reg) begin
            rank_mem[pidx_reg] <= rank_next;
        end
    end

    // Request capture and the scan for the matching, least recent and first free entries.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg       <= s_operation;
            key_in_reg   <= s_lookup_key;
            val_in_reg   <= s_write_value;
            found_reg    <= 1'b0;
            any_reg      <= 1'b0;
            free_any_reg <= 1'b0;
        end else if (pscan_reg) begin
            if (pvalid_c && (key_rd_reg == key_in_reg)) begin
                found_reg   <= 1'b1;
                slot_reg    <= pidx_reg;
                hitval_reg  <= val_rd_reg;
                hitrank_reg <= rank_rd_reg;
            end
            if (pvalid_c && (!any_reg || (rank_rd_reg > lrurank_reg))) begin
                any_reg     <= 1'b1;
                lru_reg     <= pidx_reg;
                lrurank_reg <= rank_rd_reg;
                lrukey_reg  <= key_rd_reg;
            end
            if (!pvalid_c && !free_any_reg) begin
                free_any_reg <= 1'b1;
                free_reg     <= pidx_reg;
            end
        end
    end

    // Decision and result word.
    always_ff @(posedge aclk) begin
        if (cmd.decide) begin
            ins_mode_reg <= insert_c;
            target_reg   <= target_c;
            res_hit_reg  <= found_reg;
            if (op_reg == lkv_pkg::OP_PUT) begin
                res_rd_reg <= '0;
            end else if (found_reg) begin
                res_rd_reg <= hitval_reg;
            end else begin
                res_rd_reg <= lkv_pkg::MISS_VALUE;
            end
            res_ev_reg  <= evict_c;
            res_evk_reg <= evict_c ? lrukey_reg : '0;
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_hit_reg         <= res_hit_reg;
            m_read_value_reg  <= res_rd_reg;
            m_evicted_reg     <= res_ev_reg;
            m_evicted_key_reg <= res_evk_reg;
        end
    end

    assign m_hit         = m_hit_reg;
    assign m_read_value  = m_read_value_reg;
    assign m_evicted     = m_evicted_reg;
    assign m_evicted_key = m_evicted_key_reg;

    `LKV_ASSERT(a_occ_valid, $countones(valid_reg) == int'(occ_reg), "occupancy off")
    `LKV_ASSERT(a_occ_bound, occ_reg <= CNT_W'(MAX_ENTRIES), "occupancy past the store")
    `LKV_ASSERT(a_hit_slot, (cmd.decide && found_reg) |-> valid_reg[slot_reg], "hit slot empty")

endmodule

[rtl/lru_key_value_cache_core.sv]
`timescale 1ns / 1ps
// A get miss has its result in the output register after a single sweep of the store;
// a hit or a put needs a second sweep for the ranks.
// Words are taken one at a time; the next word is taken once the result
// is in the output register, while it still waits there. A finished result whose
// predecessor has not been taken yet holds until the output register frees up.
// Reset (aresetn low, synchronous): the store is empty, capacity is 16, no result pending.

module lru_key_value_cache_core #(
    parameter int MAX_ENTRIES = 16
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [lkv_pkg::CAP_W-1:0]          cfg_wdata,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_operation,
    input  logic signed [lkv_pkg::DATA_W-1:0]  s_lookup_key,
    input  logic signed [lkv_pkg::DATA_W-1:0]  s_write_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_hit,
    output logic signed [lkv_pkg::DATA_W-1:0]  m_read_value,
    output logic                               m_evicted,
    output logic signed [lkv_pkg::DATA_W-1:0]  m_evicted_key
);

    lkv_pkg::lkv_cmd_t cmd;
    lkv_pkg::lkv_sts_t sts;

    // Sequencer for the scan, decide and rank update passes.
    lkv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .cmd     (cmd),
        .sts     (sts)
    );

    // Entry memories, recency ranks and result registers.
    lkv_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_operation   (s_operation),
        .s_lookup_key  (s_lookup_key),
        .s_write_value (s_write_value),
        .m_hit         (m_hit),
        .m_read_value  (m_read_value),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

endmodule
